>>> rtl/core/tlqc_pkg.sv
package tlqc_pkg;

  localparam int unsigned QUEUE_LIMIT = 255;
  localparam int unsigned QUEUE_CAP   = (QUEUE_LIMIT > 255) ? 255 : QUEUE_LIMIT;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_GREEN_TICKS    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_YELLOW_TICKS   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RED_TICKS      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BUSY_THRESHOLD = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BUSY_EXTENSION = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CARS_PER_TICK  = 3'd5;

  localparam logic [7:0] GREEN_TICKS_RESET    = 8'd5;
  localparam logic [7:0] YELLOW_TICKS_RESET   = 8'd2;
  localparam logic [7:0] RED_TICKS_RESET      = 8'd4;
  localparam logic [7:0] BUSY_THRESHOLD_RESET = 8'd6;
  localparam logic [5:0] BUSY_EXTENSION_RESET = 6'd2;
  localparam logic [7:0] CARS_PER_TICK_RESET  = 8'd2;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_NIGHT = 2'd2;

  localparam logic [1:0] PH_GREEN  = 2'd0;
  localparam logic [1:0] PH_YELLOW = 2'd1;
  localparam logic [1:0] PH_RED    = 2'd2;

  typedef struct packed {
    logic [7:0] green_ticks;
    logic [7:0] yellow_ticks;
    logic [7:0] red_ticks;
    logic [7:0] busy_threshold;
    logic [5:0] busy_extension;
    logic [7:0] cars_per_tick;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic        green_lamp;
    logic        yellow_lamp;
    logic        red_lamp;
    logic [7:0]  ticks_remaining;
    logic [7:0]  queue_length;
    logic [31:0] passed_count;
    logic [31:0] tick_count;
    logic        night_mode;
    logic        busy_flag;
    logic        rejected;
  } result_t;

endpackage

>>> rtl/core/tlqc_cfg.sv
module tlqc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tlqc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tlqc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output tlqc_pkg::cfg_t                   cfg
);
  import tlqc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.green_ticks    <= GREEN_TICKS_RESET;
      cfg.yellow_ticks   <= YELLOW_TICKS_RESET;
      cfg.red_ticks      <= RED_TICKS_RESET;
      cfg.busy_threshold <= BUSY_THRESHOLD_RESET;
      cfg.busy_extension <= BUSY_EXTENSION_RESET;
      cfg.cars_per_tick  <= CARS_PER_TICK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GREEN_TICKS:    cfg.green_ticks    <= cfg_data;
        REG_YELLOW_TICKS:   cfg.yellow_ticks   <= cfg_data;
        REG_RED_TICKS:      cfg.red_ticks      <= cfg_data;
        REG_BUSY_THRESHOLD: cfg.busy_threshold <= cfg_data;
        REG_BUSY_EXTENSION: cfg.busy_extension <= cfg_data[5:0];
        REG_CARS_PER_TICK:  cfg.cars_per_tick  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/tlqc_core.sv
module tlqc_core (
  input  logic              clk,
  input  logic              rst,
  input  tlqc_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        operation,
  input  logic [7:0]        arriving_cars,
  input  logic              res_can_load,
  output logic              res_load,
  output tlqc_pkg::result_t res_data
);
  import tlqc_pkg::*;

  logic        item_valid;
  logic [1:0]  item_op;
  logic [7:0]  item_cars;

  logic [1:0]  light_phase, light_phase_next;
  logic [7:0]  phase_countdown, phase_countdown_next;
  logic [7:0]  waiting_cars, waiting_cars_next;
  logic [31:0] cars_through, cars_through_next;
  logic [31:0] ticks_seen, ticks_seen_next;
  logic        night_active, night_active_next;
  logic        busy_active, busy_active_next;
  logic        blink_lit, blink_lit_next;
  logic        rejected_next;

  logic [7:0]  depart_cnt;
  logic [7:0]  waiting_after;
  logic        busy_after;
  logic [1:0]  phase_follow;
  logic [8:0]  green_sum;
  logic [7:0]  green_len;
  logic [7:0]  follow_len;
  logic [8:0]  add_sum;

  assign res_load = item_valid && res_can_load;
  assign in_ready = !item_valid || res_can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_op   <= operation;
      item_cars <= arriving_cars;
    end
  end

  // departures during a day-mode green tick
  assign depart_cnt    = (waiting_cars > cfg.cars_per_tick) ? cfg.cars_per_tick : waiting_cars;
  assign waiting_after = waiting_cars - depart_cnt;
  assign busy_after    = (light_phase == PH_GREEN && waiting_cars != 8'd0) ?
                         (waiting_after > cfg.busy_threshold) : busy_active;

  always_comb begin
    case (light_phase)
      PH_GREEN:  phase_follow = PH_YELLOW;
      PH_YELLOW: phase_follow = PH_RED;
      default:   phase_follow = PH_GREEN;
    endcase
  end

  assign green_sum = {1'b0, cfg.green_ticks} +
                     (busy_after ? {3'b000, cfg.busy_extension} : 9'd0);
  assign green_len = green_sum[8] ? 8'hFF : green_sum[7:0];

  always_comb begin
    case (phase_follow)
      PH_GREEN:  follow_len = green_len;
      PH_YELLOW: follow_len = cfg.yellow_ticks;
      default:   follow_len = cfg.red_ticks;
    endcase
  end

  assign add_sum = {1'b0, waiting_cars} + {1'b0, item_cars};

  always_comb begin
    light_phase_next     = light_phase;
    phase_countdown_next = phase_countdown;
    waiting_cars_next    = waiting_cars;
    cars_through_next    = cars_through;
    ticks_seen_next      = ticks_seen;
    night_active_next    = night_active;
    busy_active_next     = busy_active;
    blink_lit_next       = blink_lit;
    rejected_next        = 1'b0;
    case (item_op)
      OP_TICK: begin
        ticks_seen_next = ticks_seen + 32'd1;
        if (night_active) begin
          blink_lit_next = !blink_lit;
        end else begin
          if (light_phase == PH_GREEN) begin
            waiting_cars_next = waiting_after;
            cars_through_next = cars_through + {24'd0, depart_cnt};
          end
          busy_active_next = busy_after;
          if (phase_countdown <= 8'd1) begin
            light_phase_next     = phase_follow;
            phase_countdown_next = follow_len;
          end else begin
            phase_countdown_next = phase_countdown - 8'd1;
          end
        end
      end
      OP_ADD: begin
        if (add_sum > 9'(QUEUE_CAP)) begin
          rejected_next = 1'b1;
        end else begin
          waiting_cars_next = add_sum[7:0];
          busy_active_next  = add_sum[7:0] > cfg.busy_threshold;
        end
      end
      OP_NIGHT: begin
        night_active_next = !night_active;
        if (!night_active) begin
          blink_lit_next = 1'b1;
        end else begin
          light_phase_next     = PH_RED;
          phase_countdown_next = cfg.red_ticks;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light_phase     <= PH_RED;
      phase_countdown <= RED_TICKS_RESET;
      waiting_cars    <= 8'd0;
      cars_through    <= 32'd0;
      ticks_seen      <= 32'd0;
      night_active    <= 1'b0;
      busy_active     <= 1'b0;
      blink_lit       <= 1'b0;
    end else if (res_load) begin
      light_phase     <= light_phase_next;
      phase_countdown <= phase_countdown_next;
      waiting_cars    <= waiting_cars_next;
      cars_through    <= cars_through_next;
      ticks_seen      <= ticks_seen_next;
      night_active    <= night_active_next;
      busy_active     <= busy_active_next;
      blink_lit       <= blink_lit_next;
    end
  end

  always_comb begin
    res_data.phase           = light_phase_next;
    res_data.green_lamp      = !night_active_next && light_phase_next == PH_GREEN;
    res_data.yellow_lamp     = night_active_next ? blink_lit_next :
                               (light_phase_next == PH_YELLOW);
    res_data.red_lamp        = !night_active_next && light_phase_next == PH_RED;
    res_data.ticks_remaining = phase_countdown_next;
    res_data.queue_length    = waiting_cars_next;
    res_data.passed_count    = cars_through_next;
    res_data.tick_count      = ticks_seen_next;
    res_data.night_mode      = night_active_next;
    res_data.busy_flag       = busy_active_next;
    res_data.rejected        = rejected_next;
  end

endmodule

>>> rtl/core/tlqc_out.sv
module tlqc_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_load,
  input  tlqc_pkg::result_t res_data,
  output logic              res_can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output tlqc_pkg::result_t res
);
  import tlqc_pkg::*;

  assign res_can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_can_load) begin
      out_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_data;
    end
  end

endmodule

>>> rtl/core/traffic_light_queue_controller_top.sv
// Traffic light with a waiting-car queue. Each input transaction (tick, add cars,
// toggle night mode) yields exactly one result transaction carrying lamps,
// countdown, queue length, counters and flags. Throughput is one transaction per
// cycle while out_ready does not hold back results. An accepted transaction is
// held in the input register while the single state-update stage works on it,
// and its result is then written to the result register. A result held by
// out_ready low stalls the input once the input register is occupied.
// Configuration writes take effect at once and should only be made while idle.
module traffic_light_queue_controller_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tlqc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tlqc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       operation,
  input  logic [7:0]                       arriving_cars,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       phase,
  output logic                             green_lamp,
  output logic                             yellow_lamp,
  output logic                             red_lamp,
  output logic [7:0]                       ticks_remaining,
  output logic [7:0]                       queue_length,
  output logic [31:0]                      passed_count,
  output logic [31:0]                      tick_count,
  output logic                             night_mode,
  output logic                             busy_flag,
  output logic                             rejected
);
  import tlqc_pkg::*;

  cfg_t    cfg;
  result_t res_data;
  result_t res;
  logic    res_load;
  logic    res_can_load;

  tlqc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tlqc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .arriving_cars (arriving_cars),
    .res_can_load  (res_can_load),
    .res_load      (res_load),
    .res_data      (res_data)
  );

  tlqc_out u_out (
    .clk          (clk),
    .rst          (rst),
    .res_load     (res_load),
    .res_data     (res_data),
    .res_can_load (res_can_load),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .res          (res)
  );

  assign phase           = res.phase;
  assign green_lamp      = res.green_lamp;
  assign yellow_lamp     = res.yellow_lamp;
  assign red_lamp        = res.red_lamp;
  assign ticks_remaining = res.ticks_remaining;
  assign queue_length    = res.queue_length;
  assign passed_count    = res.passed_count;
  assign tick_count      = res.tick_count;
  assign night_mode      = res.night_mode;
  assign busy_flag       = res.busy_flag;
  assign rejected        = res.rejected;

endmodule

>>> sim/tb_traffic_light_queue_controller_top.sv
`timescale 1ns / 100ps

import tlqc_pkg::*;

class light_scoreboard;
  logic [7:0]  green_len, yellow_len, red_len, busy_level, per_tick;
  logic [5:0]  busy_bonus;
  logic [1:0]  light;
  logic [7:0]  countdown, waiting;
  logic [31:0] passed, ticks;
  bit          night, busy, blink;
  result_t     pending_lights[$];
  int unsigned errors;

  function new();
    green_len  = GREEN_TICKS_RESET;
    yellow_len = YELLOW_TICKS_RESET;
    red_len    = RED_TICKS_RESET;
    busy_level = BUSY_THRESHOLD_RESET;
    busy_bonus = BUSY_EXTENSION_RESET;
    per_tick   = CARS_PER_TICK_RESET;
    light      = PH_RED;
    countdown  = RED_TICKS_RESET;
    waiting    = '0;
    passed     = '0;
    ticks      = '0;
    night      = 1'b0;
    busy       = 1'b0;
    blink      = 1'b0;
    errors     = 0;
  endfunction

  function int pending();
    return pending_lights.size();
  endfunction

  function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_GREEN_TICKS:    green_len  = data;
      REG_YELLOW_TICKS:   yellow_len = data;
      REG_RED_TICKS:      red_len    = data;
      REG_BUSY_THRESHOLD: busy_level = data;
      REG_BUSY_EXTENSION: busy_bonus = data[5:0];
      REG_CARS_PER_TICK:  per_tick   = data;
      default: ;
    endcase
  endfunction

  function logic [7:0] load_length(logic [1:0] p);
    int unsigned g;
    if (p == PH_GREEN) begin
      g = int'(green_len) + (busy ? int'(busy_bonus) : 0);
      return (g > 255) ? 8'd255 : g[7:0];
    end
    return (p == PH_YELLOW) ? yellow_len : red_len;
  endfunction

  function void tick_step();
    logic [7:0] go;
    ticks = ticks + 32'd1;
    if (night) begin
      blink = !blink;
      return;
    end
    if (light == PH_GREEN && waiting != 8'd0) begin
      go = (waiting > per_tick) ? per_tick : waiting;
      waiting = waiting - go;
      passed = passed + {24'd0, go};
      busy = waiting > busy_level;
    end
    if (countdown <= 8'd1) begin
      case (light)
        PH_GREEN:  light = PH_YELLOW;
        PH_YELLOW: light = PH_RED;
        default:   light = PH_GREEN;
      endcase
      countdown = load_length(light);
    end else begin
      countdown = countdown - 8'd1;
    end
  endfunction

  function void predict_event(logic [1:0] op, logic [7:0] cars);
    result_t r;
    bit      refused;
    refused = 1'b0;
    case (op)
      OP_TICK: tick_step();
      OP_ADD: begin
        if (int'(cars) > int'(QUEUE_CAP) - int'(waiting)) begin
          refused = 1'b1;
        end else begin
          waiting = waiting + cars;
          busy = waiting > busy_level;
        end
      end
      OP_NIGHT: begin
        night = !night;
        if (night) begin
          blink = 1'b1;
        end else begin
          light = PH_RED;
          countdown = red_len;
        end
      end
      default: ;
    endcase
    r.phase           = light;
    r.green_lamp      = !night && light == PH_GREEN;
    r.yellow_lamp     = night ? blink : (light == PH_YELLOW);
    r.red_lamp        = !night && light == PH_RED;
    r.ticks_remaining = countdown;
    r.queue_length    = waiting;
    r.passed_count    = passed;
    r.tick_count      = ticks;
    r.night_mode      = night;
    r.busy_flag       = busy;
    r.rejected        = refused;
    pending_lights.push_back(r);
  endfunction

  function void show(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) $display("  %-15s expected 0x%0h actual 0x%0h", name, want, got);
  endfunction

  function void check_lights(result_t got);
    result_t want;
    if (pending_lights.size() == 0) begin
      errors++;
      if (errors <= 10) $display("result transaction with nothing outstanding");
      return;
    end
    want = pending_lights.pop_front();
    if (got === want) return;
    errors++;
    if (errors > 10) return;
    $display("result mismatch at %0t", $time);
    show("phase", want.phase, got.phase);
    show("green_lamp", want.green_lamp, got.green_lamp);
    show("yellow_lamp", want.yellow_lamp, got.yellow_lamp);
    show("red_lamp", want.red_lamp, got.red_lamp);
    show("ticks_remaining", want.ticks_remaining, got.ticks_remaining);
    show("queue_length", want.queue_length, got.queue_length);
    show("passed_count", want.passed_count, got.passed_count);
    show("tick_count", want.tick_count, got.tick_count);
    show("night_mode", want.night_mode, got.night_mode);
    show("busy_flag", want.busy_flag, got.busy_flag);
    show("rejected", want.rejected, got.rejected);
  endfunction
endclass

module tb_traffic_light_queue_controller_top;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_B = 3'd7;
  localparam int unsigned STALL_LIMIT = 2000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             operation = OP_TICK;
  logic [7:0]             arriving_cars = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             phase;
  logic                   green_lamp, yellow_lamp, red_lamp;
  logic [7:0]             ticks_remaining, queue_length;
  logic [31:0]            passed_count, tick_count;
  logic                   night_mode, busy_flag, rejected;

  result_t         dut_lights;
  light_scoreboard board = new();
  bit              quiet = 1'b0;
  int unsigned     idle_cycles = 0;

  traffic_light_queue_controller_top i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .arriving_cars   (arriving_cars),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .phase           (phase),
    .green_lamp      (green_lamp),
    .yellow_lamp     (yellow_lamp),
    .red_lamp        (red_lamp),
    .ticks_remaining (ticks_remaining),
    .queue_length    (queue_length),
    .passed_count    (passed_count),
    .tick_count      (tick_count),
    .night_mode      (night_mode),
    .busy_flag       (busy_flag),
    .rejected        (rejected)
  );

  always #5 clk = ~clk;

  assign dut_lights = {phase, green_lamp, yellow_lamp, red_lamp, ticks_remaining,
                       queue_length, passed_count, tick_count, night_mode, busy_flag,
                       rejected};

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_lights(dut_lights);
  end

  initial begin
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet && $urandom_range(0, 1) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // no transaction for too long
  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("traffic_light_queue_controller_top verification failed");
    $finish;
  end

  task automatic present_event(input logic [1:0] op, input logic [7:0] cars);
    in_valid      <= 1'b1;
    operation     <= op;
    arriving_cars <= cars;
    do @(posedge clk); while (!in_ready);
    board.predict_event(op, cars);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  task automatic program_lights(input logic [7:0] g, y, r, t, x, c, input bit alt);
    cfg_write(REG_GREEN_TICKS, g);
    cfg_write(REG_YELLOW_TICKS, y);
    cfg_write(REG_RED_TICKS, r);
    cfg_write(REG_BUSY_THRESHOLD, t);
    cfg_write(REG_BUSY_EXTENSION, x);
    cfg_write(REG_CARS_PER_TICK, c);
    cfg_write(alt ? REG_UNUSED_B : REG_UNUSED_A, 8'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic random_event();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 57) begin
      present_event(OP_TICK, 8'($urandom));
    end else if (pick < 87) begin
      present_event(OP_ADD, ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(0, 12)));
    end else if (pick < 95) begin
      present_event(OP_NIGHT, 8'($urandom));
    end else begin
      present_event(OP_SPARE, 8'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // red countdown, then queue limit around a full queue
    present_event(OP_TICK, 8'hFF);
    present_event(OP_TICK, 8'h00);
    present_event(OP_ADD, 8'd0);
    present_event(OP_ADD, 8'd255);
    present_event(OP_ADD, 8'd1);
    present_event(OP_TICK, 8'h00);
    present_event(OP_TICK, 8'h00);
    present_event(OP_TICK, 8'h55);
    present_event(OP_SPARE, 8'hAA);
    // night mode in and out
    present_event(OP_NIGHT, 8'h00);
    present_event(OP_TICK, 8'h00);
    present_event(OP_TICK, 8'h00);
    present_event(OP_ADD, 8'd3);
    present_event(OP_NIGHT, 8'hFF);
    repeat (5) present_event(OP_TICK, 8'h00);
    present_event(OP_ADD, 8'hAA);
    present_event(OP_NIGHT, 8'h00);
    present_event(OP_NIGHT, 8'h00);
    wait_quiet();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: program_lights(8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd1, 1'b0);
        1: program_lights(8'd200, 8'd255, 8'd255, 8'd255, 8'd55, 8'd255, 1'b1);
        2: program_lights(8'd250, 8'd0, 8'd0, 8'd3, 8'hFF, 8'd255, 1'b0);
        3: program_lights(GREEN_TICKS_RESET, YELLOW_TICKS_RESET, RED_TICKS_RESET,
                          BUSY_THRESHOLD_RESET, {2'b00, BUSY_EXTENSION_RESET},
                          CARS_PER_TICK_RESET, 1'b1);
        default: program_lights(8'($urandom_range(1, 12)), 8'($urandom_range(1, 6)),
                                8'($urandom_range(1, 8)), 8'($urandom_range(0, 30)),
                                8'($urandom_range(0, 55)), 8'($urandom_range(1, 6)),
                                ph[0]);
      endcase
      if (ph == 7) quiet = 1'b1;
      for (int i = 0; i < 180; i++) begin
        if (ph == 4 && i == 90) wait_quiet();
        sender_gap();
        random_event();
      end
      wait_quiet();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("traffic_light_queue_controller_top verification clean");
    end else begin
      $display("traffic_light_queue_controller_top verification failed");
    end
    $finish;
  end

endmodule
